// ===== sv/ccrc_pkg.sv =====
package ccrc_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_TOP_BIT  = 32'h8000_0000;

   localparam logic [31:0] POLY_RESET     = 32'h04C1_1DB7;
   localparam logic [31:0] XOR_OUT_RESET  = 32'hFFFF_FFFF;

   localparam logic [2:0] BYTES_PER_WORD = 3'd4;

   // register index, byte address is 4 * index
   typedef enum logic [2:0] {
      REG_POLY      = 3'd0,
      REG_REFL_IN   = 3'd1,
      REG_REFL_OUT  = 3'd2,
      REG_XOR_OUT   = 3'd3,
      REG_WORD_MODE = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [31:0] crc_value;
      logic        length_error;
   } rsp_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [31:0] generator_polynomial;
      logic        reflect_input_bytes;
      logic        reflect_output_crc;
      logic [31:0] output_xor_value;
      logic        word_order_mode;
   } cfg_type;

   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = b[i];
      end
      return r;
   endfunction

   function automatic logic [31:0] rev32(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[31-i] = v[i];
      end
      return r;
   endfunction

   // one byte through the MSB-first shift register, eight bit steps
   function automatic logic [31:0] fold_byte(
      input logic [31:0] crc,
      input logic [7:0]  data,
      input logic [31:0] poly,
      input logic        refl
   );
      logic [7:0]  b;
      logic [31:0] c;
      b = refl ? rev8(data) : data;
      c = crc ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP_BIT) != 32'h0) begin
            c = {c[30:0], 1'b0} ^ poly;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/ccrc_csr.sv =====
module ccrc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ccrc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ccrc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ccrc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output ccrc_pkg::cfg_type              cfg
);
   import ccrc_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_POLY:      cfg_in.generator_polynomial = csr_pwdata;
            REG_REFL_IN:   cfg_in.reflect_input_bytes  = csr_pwdata[0];
            REG_REFL_OUT:  cfg_in.reflect_output_crc   = csr_pwdata[0];
            REG_XOR_OUT:   cfg_in.output_xor_value     = csr_pwdata;
            REG_WORD_MODE: cfg_in.word_order_mode      = csr_pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.generator_polynomial <= POLY_RESET;
         cfg_ff.reflect_input_bytes  <= 1'b1;
         cfg_ff.reflect_output_crc   <= 1'b1;
         cfg_ff.output_xor_value     <= XOR_OUT_RESET;
         cfg_ff.word_order_mode      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_POLY:      csr_prdata = cfg_ff.generator_polynomial;
         REG_REFL_IN:   csr_prdata = {31'h0, cfg_ff.reflect_input_bytes};
         REG_REFL_OUT:  csr_prdata = {31'h0, cfg_ff.reflect_output_crc};
         REG_XOR_OUT:   csr_prdata = cfg_ff.output_xor_value;
         REG_WORD_MODE: csr_prdata = {31'h0, cfg_ff.word_order_mode};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/ccrc_engine.sv =====
module ccrc_engine (
   input  logic              clock,
   input  logic              reset,
   input  ccrc_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  ccrc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ccrc_pkg::rsp_type rsp_payload
);
   import ccrc_pkg::*;

   req_type     in_ff;
   logic        in_vld_ff;
   logic        in_vld_in;
   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic        err_ff;
   logic        err_in;
   rsp_type     out_ff;
   rsp_type     out_in;
   logic        out_vld_ff;
   logic        out_vld_in;

   logic        advance;
   logic        req_take;
   logic [2:0]  count_sat;
   logic [7:0]  seq_byte [4];
   logic [3:0]  seq_en;
   logic [31:0] fold_crc [5];
   logic        err_next;
   logic [31:0] crc_out;

   // a non-last request never needs the result slot
   assign advance   = in_vld_ff & (~in_ff.last_item | ~out_vld_ff | ~rsp_stall);
   assign req_stall = in_vld_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   // byte order and enables: word mode folds 3..0, byte mode 0..count-1
   always_comb begin
      count_sat = (in_ff.byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : in_ff.byte_count;
      for (int k = 0; k < 4; k++) begin
         if (cfg.word_order_mode) begin
            seq_byte[k] = in_ff.data_word[8*(3-k) +: 8];
            seq_en[k]   = 1'b1;
         end else begin
            seq_byte[k] = in_ff.data_word[8*k +: 8];
            seq_en[k]   = (3'(k) < count_sat);
         end
      end
   end

   // four byte folds in a row
   always_comb begin
      fold_crc[0] = crc_ff;
      for (int k = 0; k < 4; k++) begin
         fold_crc[k+1] = seq_en[k] ?
            fold_byte(fold_crc[k], seq_byte[k], cfg.generator_polynomial,
                      cfg.reflect_input_bytes) : fold_crc[k];
      end
   end

   assign err_next = err_ff | (cfg.word_order_mode & (count_sat < BYTES_PER_WORD));
   assign crc_out  = (cfg.reflect_output_crc ? rev32(fold_crc[4]) : fold_crc[4])
                     ^ cfg.output_xor_value;

   // next state
   always_comb begin
      in_vld_in  = in_vld_ff;
      crc_in     = crc_ff;
      err_in     = err_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff & rsp_stall;
      if (advance) begin
         in_vld_in = 1'b0;
         if (in_ff.last_item) begin
            crc_in     = CRC_ALL_ONES;
            err_in     = 1'b0;
            out_vld_in = 1'b1;
            out_in.length_error = err_next;
            out_in.crc_value    = err_next ? 32'h0 : crc_out;
         end else begin
            crc_in = fold_crc[4];
            err_in = err_next;
         end
      end
      if (req_take) begin
         in_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         crc_ff     <= CRC_ALL_ONES;
         err_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         crc_ff     <= crc_in;
         err_ff     <= err_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_take) begin
         in_ff <= req_payload;
      end
      out_ff <= out_in;
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   // message end restarts the running state
   a_restart: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.last_item |=> crc_ff == CRC_ALL_ONES && !err_ff)
      else $error("running state not restarted after last request");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.length_error |-> out_ff.crc_value == 32'h0)
      else $error("length error result with nonzero crc");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && in_ff.last_item && out_vld_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_stall |=> out_vld_ff && $stable(out_ff))
      else $error("held result lost or overwritten");

endmodule

// ===== sv/configurable_crc32_engine_core.sv =====
// Flow: a request accepted into the input register is folded from there into the
//   running CRC register; a last request instead loads the result register,
//   which drives rsp_valid until the result is taken.
// Throughput: one request per cycle when not stalled; the four byte folds of a
//   word run combinationally on the running CRC register. Stall: a last request
//   waits in the input register while an earlier result is held by rsp_stall.
// Reset: synchronous, active high; clears the pipeline, restarts the CRC at
//   all ones and loads the configuration registers with their defaults.
module configurable_crc32_engine_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ccrc_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ccrc_pkg::rsp_type               rsp_payload,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ccrc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ccrc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ccrc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import ccrc_pkg::*;

   cfg_type cfg;

   // configuration registers
   ccrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // CRC datapath
   ccrc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ccrc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned ITEM_TARGET  = 450;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned MAX_WAIT     = 17;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // idling control and run statistics
   bit          req_quiet     = 1'b0;
   bit          rsp_quiet     = 1'b0;
   logic        word_mode_now = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count   = 0;

   // running CRC predictor plus the queue of CRC results still owed by the block
   class crc_scoreboard;
      logic [31:0] poly;
      logic        refl_in;
      logic        refl_out;
      logic [31:0] xor_out;
      logic        word_mode;
      logic [31:0] crc_acc;
      logic        short_seen;
      rsp_type     expected_crcs[$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         poly       = POLY_RESET;
         refl_in    = 1'b1;
         refl_out   = 1'b1;
         xor_out    = XOR_OUT_RESET;
         word_mode  = 1'b0;
         crc_acc    = CRC_ALL_ONES;
         short_seen = 1'b0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_register(reg_idx_type idx, logic [31:0] value);
         case (idx)
            REG_POLY:      poly      = value;
            REG_REFL_IN:   refl_in   = value[0];
            REG_REFL_OUT:  refl_out  = value[0];
            REG_XOR_OUT:   xor_out   = value;
            REG_WORD_MODE: word_mode = value[0];
            default: ;
         endcase
      endfunction

      // one message byte, eight MSB-first shift steps
      function void absorb_byte(logic [7:0] data);
         logic [7:0]  b;
         logic [31:0] c;
         int          i;
         for (i = 0; i < 8; i++) b[i] = refl_in ? data[7-i] : data[i];
         c = crc_acc ^ {b, 24'h0};
         for (i = 0; i < 8; i++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ poly) : {c[30:0], 1'b0};
         end
         crc_acc = c;
      endfunction

      function void note_request(req_type r);
         logic [2:0]  n;
         logic [31:0] fin;
         rsp_type     res;
         int          k;
         n = (r.byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : r.byte_count;
         if (word_mode) begin
            // whole word, high byte first; short words poison the message
            if (n < BYTES_PER_WORD) short_seen = 1'b1;
            for (k = 3; k >= 0; k--) absorb_byte(r.data_word[8*k +: 8]);
         end else begin
            for (k = 0; k < int'(n); k++) absorb_byte(r.data_word[8*k +: 8]);
         end
         if (r.last_item) begin
            if (short_seen) begin
               res.crc_value    = '0;
               res.length_error = 1'b1;
            end else begin
               for (k = 0; k < 32; k++) fin[k] = refl_out ? crc_acc[31-k] : crc_acc[k];
               res.crc_value    = fin ^ xor_out;
               res.length_error = 1'b0;
            end
            expected_crcs.push_back(res);
            crc_acc    = CRC_ALL_ONES;
            short_seen = 1'b0;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_crcs.size() == 0) begin
            $error("unexpected result: crc_value %h, length_error %b",
                   got.crc_value, got.length_error);
            mismatches++;
            return;
         end
         want = expected_crcs.pop_front();
         checked++;
         if (got.crc_value !== want.crc_value) begin
            $error("crc_value: expected %h, got %h", want.crc_value, got.crc_value);
            mismatches++;
         end
         if (got.length_error !== want.length_error) begin
            $error("length_error: expected %b, got %b",
                   want.length_error, got.length_error);
            mismatches++;
         end
      endfunction
   endclass

   crc_scoreboard crc_check = new();

   configurable_crc32_engine_core i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_payload,
      .rsp_valid,
      .rsp_stall,
      .rsp_payload,
      .csr_psel,
      .csr_penable,
      .csr_pwrite,
      .csr_paddr,
      .csr_pwdata,
      .csr_prdata,
      .csr_pready
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int unsigned draw_wait(bit quiet);
      if (quiet || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // result side: random stall ahead of each result
   initial begin
      int unsigned hold;
      bit          seen;
      forever begin
         hold = draw_wait(rsp_quiet);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         // handshake signals only move at rising edges; look mid-cycle
         do begin
            @(negedge clock);
            seen = rsp_valid;
            @(posedge clock);
         end while (!seen);
      end
   end

   // result monitor: a result seen mid-cycle is taken at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         crc_check.check_result(rsp_payload);
      end
   end

   // one request, with a random gap ahead of it
   task automatic send_request(input logic [31:0] data, input logic [2:0] count,
                               input logic last);
      int unsigned gap;
      req_type     r;
      bit          stalled;
      r.data_word  = data;
      r.byte_count = count;
      r.last_item  = last;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      // stall only moves at rising edges; its mid-cycle value holds at the next one
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      crc_check.note_request(r);
      requests_sent++;
   endtask

   // drop valid, wait for every owed result, then let the pipeline empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (crc_check.expected_crcs.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // setup then access phase; psel stays up for back-to-back writes
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      crc_check.set_register(idx, value);
   endtask

   task automatic apply_setting(input logic [31:0] poly, input logic rin,
                                input logic rout, input logic [31:0] xo,
                                input logic wm);
      csr_write(REG_POLY, poly);
      csr_write(REG_REFL_IN, {31'b0, rin});
      csr_write(REG_REFL_OUT, {31'b0, rout});
      csr_write(REG_XOR_OUT, xo);
      csr_write(REG_WORD_MODE, {31'b0, wm});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      word_mode_now = wm;
      settings_used++;
   endtask

   // mostly well-formed counts for the current mode, some noise
   function automatic logic [2:0] pick_count(logic last);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 3'($urandom_range(0, 7));
      if (word_mode_now) return (roll < 18) ? 3'($urandom_range(5, 7)) : BYTES_PER_WORD;
      if (last) return 3'($urandom_range(1, 4));
      return BYTES_PER_WORD;
   endfunction

   // random messages; optionally leave the final one open across a reconfig
   task automatic run_messages(input int unsigned n_items, input bit leave_open);
      int unsigned left;
      int unsigned len;
      int unsigned i;
      logic        last;
      left = n_items;
      while (left > 0) begin
         len = $urandom_range(1, 8);
         if (len > left) len = left;
         for (i = 0; i < len; i++) begin
            last = (i == len - 1) && !(leave_open && len == left);
            send_request($urandom(), pick_count(last), last);
         end
         left -= len;
      end
   endtask

   initial begin
      int unsigned phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // byte mode, reset configuration: check string, extremes, odd counts
      send_request(32'h3433_3231, 3'd4, 1'b0);
      send_request(32'h3837_3635, 3'd4, 1'b0);
      send_request(32'h0000_0039, 3'd1, 1'b1);
      send_request(32'hFFFF_FFFF, 3'd4, 1'b1);
      send_request(32'h0000_0000, 3'd4, 1'b1);
      send_request(32'h1234_5678, 3'd0, 1'b1);   // empty message
      send_request(32'hA5A5_A5A5, 3'd7, 1'b0);   // counts above four saturate
      send_request(32'h5A5A_5A5A, 3'd5, 1'b0);
      send_request(32'hDEAD_BEEF, 3'd6, 1'b1);
      send_request(32'hCAFE_F00D, 3'd2, 1'b0);
      send_request(32'h0BAD_C0DE, 3'd0, 1'b0);   // zero count mid-message
      send_request(32'h8765_4321, 3'd3, 1'b1);

      // word mode: good words, short words, zero count, saturated count
      wait_idle();
      apply_setting(POLY_RESET, 1'b1, 1'b1, XOR_OUT_RESET, 1'b1);
      send_request(32'h0102_0304, 3'd4, 1'b0);
      send_request(32'h0506_0708, 3'd4, 1'b1);
      send_request(32'hFFFF_FFFF, 3'd2, 1'b1);
      send_request(32'h1122_3344, 3'd0, 1'b0);
      send_request(32'h5566_7788, 3'd4, 1'b1);
      send_request(32'h99AA_BBCC, 3'd7, 1'b1);
      send_request(32'h1357_9BDF, 3'd1, 1'b0);   // short word, message stays open

      // mode flips mid-message: the length error must stick
      wait_idle();
      apply_setting(POLY_RESET, 1'b1, 1'b1, XOR_OUT_RESET, 1'b0);
      send_request(32'h2468_ACE0, 3'd3, 1'b1);
      send_request(32'h0000_0000, 3'd4, 1'b0);
      wait_idle();
      apply_setting(POLY_RESET, 1'b0, 1'b0, 32'h0, 1'b1);
      send_request(32'hFFFF_FFFF, 3'd4, 1'b1);

      // random phases over extreme and random settings
      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         case (phase)
            0: apply_setting(POLY_RESET, 1'b1, 1'b1, XOR_OUT_RESET, 1'b0);
            1: apply_setting(32'h0, 1'b0, 1'b0, 32'h0, 1'b0);
            2: apply_setting(CRC_ALL_ONES, 1'b1, 1'b0, CRC_ALL_ONES, 1'b1);
            3: apply_setting($urandom(), 1'b0, 1'b1, $urandom(), 1'b0);
            default: apply_setting($urandom(), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), $urandom(),
                                   1'($urandom_range(0, 1)));
         endcase
         run_messages(ITEM_TARGET / PHASES,
                      (phase != PHASES - 1) && ($urandom_range(0, 2) == 0));
      end

      wait_idle();
      if (crc_check.expected_crcs.size() != 0) begin
         $error("%0d expected CRC results never arrived", crc_check.expected_crcs.size());
         crc_check.mismatches++;
      end
      $display("Sent %0d requests across %0d register settings (byte and word mode).",
               requests_sent, settings_used);
      $display("Checked %0d CRC results, %0d mismatches.",
               crc_check.checked, crc_check.mismatches);
      if (crc_check.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
